>>> hdl/lssp_pkg.sv
// Package for the load-shedding stage policy block.
// Shared types, stage count, event codes and configuration register indexes.
// No dependencies.
package lssp_pkg;

  localparam int NUM_STAGES = 10;
  localparam int IDX_W      = 4;
  localparam int RTF_W      = 16;
  localparam int RCNT_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // One in Q4.12, and the shed / recover thresholds as fractions of it.
  localparam int RTF_ONE = 4096;
  localparam int HI_NUM  = 4;
  localparam int HI_DEN  = 5;
  localparam int LO_NUM  = 1;
  localparam int LO_DEN  = 2;

  typedef logic [NUM_STAGES-1:0] stage_mask_t;
  typedef logic [IDX_W-1:0]      stage_idx_t;
  typedef logic [1:0]            ev_kind_t;
  typedef logic [RCNT_W-1:0]     rcnt_t;
  typedef logic [RTF_W-1:0]      rtf_t;

  localparam ev_kind_t EV_NONE    = 2'd0;
  localparam ev_kind_t EV_SHED    = 2'd1;
  localparam ev_kind_t EV_RESTORE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MONITOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY = 2'd2;

  localparam stage_mask_t ACTIVE_RST   = 10'h3FF;
  localparam rcnt_t       RECOVERY_RST = 10'd32;

  // Stage choice for the current beat.
  typedef struct packed {
    logic       shed_ok;   // some requested stage is still running
    stage_idx_t shed_idx;  // cheapest such stage
    stage_idx_t rest_idx;  // highest-numbered shed stage
  } sel_t;

endpackage

>>> hdl/load_shedding_stage_policy.sv
// Load-shedding stage policy, top level.
// Depends on lssp_pkg and lssp_stage_sel.
//
// Each input beat carries the load ratio of one processed audio block
// (unsigned Q4.12). While monitoring is enabled the value goes into a ring of
// WINDOW entries and a running sum is kept; once the window is full every beat
// publishes the truncated window average on rolling_load. A window sum above
// 0.80 of budget sheds the cheapest requested stage that is still running and
// restarts the window; a sum below 0.50 with some stage shed advances a
// recovery counter, and when it reaches recovery_blocks the highest-numbered
// shed stage is restored. Every input beat yields exactly one result beat. The
// block takes one beat per clock and delivers one per clock when the output
// is not stalled. It is pipelined as an input register, the policy stage
// (running sum, ring access, priority encoders) and the average stage, where
// the window sum is divided by WINDOW through a constant reciprocal multiply.
// The ring is a memory with one write port and one read port, read one beat
// ahead, so its read data is ready when the next beat arrives.
// Configuration writes are taken in any cycle (cfg_ready is tied high) and
// must only be issued while the block is idle; writes to an unknown index are
// dropped.
module load_shedding_stage_policy #(
  parameter int WINDOW = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lssp_pkg::rtf_t                      in_block_rtf,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output lssp_pkg::stage_mask_t               out_shed_mask,
  output lssp_pkg::stage_mask_t               out_effective_stages,
  output lssp_pkg::rtf_t                      out_rolling_load,
  output lssp_pkg::ev_kind_t                  out_event_kind,
  output lssp_pkg::stage_idx_t                out_event_stage,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lssp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lssp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lssp_pkg::*;

  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = RTF_W + $clog2(WINDOW);
  localparam int CMP_W  = SUM_W + 3;

  // Thresholds on the window sum: high when 5*sum > 4*ONE*W,
  // low when 2*sum < ONE*W.
  localparam logic [CMP_W-1:0] HI_LIM = CMP_W'(HI_NUM * RTF_ONE * WINDOW);
  localparam logic [CMP_W-1:0] LO_LIM = CMP_W'(LO_NUM * RTF_ONE * WINDOW);

  // Exact floor(sum / WINDOW) for any sum below 2**SUM_W:
  // q = (sum * ceil(2**DIV_S / WINDOW)) >> DIV_S.
  localparam int DIV_S   = SUM_W + $clog2(WINDOW);
  localparam int DIV_M_W = SUM_W + 2;
  localparam int PROD_W  = SUM_W + DIV_M_W;
  localparam logic [DIV_M_W-1:0] DIV_M =
    DIV_M_W'(((64'd1 << DIV_S) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);

  // ---------------------------------------------------------------- config
  stage_mask_t active_r;
  logic        monitor_r;
  rcnt_t       recovery_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= ACTIVE_RST;
      monitor_r  <= 1'b1;
      recovery_r <= RECOVERY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACTIVE:   active_r   <= cfg_data[NUM_STAGES-1:0];
        CFG_MONITOR:  monitor_r  <= cfg_data[0];
        CFG_RECOVERY: recovery_r <= cfg_data[RCNT_W-1:0];
        default: ; // unknown index: drop the write
      endcase
    end
  end

  // ------------------------------------------------------------ flow control
  // Three registered stages: s1 (input), s2 (policy result), out (average).
  logic s1_valid_r;
  logic s2_valid_r;
  logic out_valid_r;
  logic out_free;
  logic s2_free;
  logic s1_fire;
  logic s2_fire;

  assign out_free = !out_valid_r || !out_stall;
  assign s2_fire  = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_fire  = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s2_free) begin
        s2_valid_r <= s1_fire;
      end
      if (out_free) begin
        out_valid_r <= s2_fire;
      end
    end
  end

  // ------------------------------------------------------------ input stage
  rtf_t s1_rtf_r;

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_rtf_r <= in_block_rtf;
    end
  end

  // ----------------------------------------------------------- policy stage
  rtf_t              ring [WINDOW];
  rtf_t              ring_rd_r;    // entry at wr_ptr_r, fetched a beat ahead
  logic [PTR_W-1:0]  wr_ptr_r,  wr_ptr_nxt;
  logic [FILL_W-1:0] fill_r,    fill_nxt;
  logic [SUM_W-1:0]  sum_r,     sum_nxt;
  stage_mask_t       shed_r,    shed_nxt;
  rcnt_t             rcnt_r,    rcnt_nxt;

  logic              upd;          // accepted beat with monitoring on
  logic              full_in;
  logic [FILL_W-1:0] fill_add;
  logic [SUM_W-1:0]  sum_add;
  logic [CMP_W-1:0]  sum5;
  logic [CMP_W-1:0]  sum2;
  logic              hi_load;
  logic              lo_load;
  rcnt_t             rcnt_inc;
  logic              publish;
  ev_kind_t          kind;
  stage_idx_t        stage;
  sel_t              sel;

  lssp_stage_sel u_sel (
    .active (active_r),
    .shed   (shed_r),
    .sel    (sel)
  );

  assign upd     = s1_fire && monitor_r;
  assign full_in = (fill_r == FILL_MAX);

  always_comb begin
    // slide the window: drop the oldest entry once the window is full
    if (full_in) begin
      sum_add  = sum_r - SUM_W'(ring_rd_r) + SUM_W'(s1_rtf_r);
      fill_add = fill_r;
    end else begin
      sum_add  = sum_r + SUM_W'(s1_rtf_r);
      fill_add = fill_r + FILL_W'(1);
    end

    sum5     = (CMP_W'(sum_add) << 2) + CMP_W'(sum_add);
    sum2     = CMP_W'(sum_add) << 1;
    hi_load  = sum5 > HI_LIM;
    lo_load  = sum2 < LO_LIM;
    rcnt_inc = rcnt_r + RCNT_W'(1);
    publish  = (fill_add == FILL_MAX);

    wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    fill_nxt   = fill_add;
    sum_nxt    = sum_add;
    shed_nxt   = shed_r;
    rcnt_nxt   = rcnt_r;
    kind       = EV_NONE;
    stage      = '0;

    if (publish) begin
      if (hi_load) begin
        rcnt_nxt = '0;
        if (sel.shed_ok) begin
          // shed one stage and restart the window
          shed_nxt   = shed_r | (stage_mask_t'(1) << sel.shed_idx);
          kind       = EV_SHED;
          stage      = sel.shed_idx;
          fill_nxt   = '0;
          wr_ptr_nxt = '0;
          sum_nxt    = '0;
        end
      end else if (lo_load && (shed_r != '0)) begin
        rcnt_nxt = rcnt_inc;
        if (rcnt_inc >= recovery_r) begin
          rcnt_nxt = '0;
          shed_nxt = shed_r & ~(stage_mask_t'(1) << sel.rest_idx);
          kind     = EV_RESTORE;
          stage    = sel.rest_idx;
        end
      end else begin
        rcnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
      shed_r   <= '0;
      rcnt_r   <= '0;
    end else if (upd) begin
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
      sum_r    <= sum_nxt;
      shed_r   <= shed_nxt;
      rcnt_r   <= rcnt_nxt;
    end
  end

  // Ring: write the new sample, fetch the entry the next beat will drop.
  // After a window restart the fetched entry is stale but stays unused
  // until the window has been refilled, by which time it has been refetched.
  always_ff @(posedge clk) begin
    if (upd) begin
      ring[wr_ptr_r] <= s1_rtf_r;
      ring_rd_r      <= ring[wr_ptr_nxt];
    end
  end

  // Policy result register.
  logic [SUM_W-1:0] s2_sum_r;
  logic             s2_pub_r;
  stage_mask_t      s2_shed_r;
  stage_mask_t      s2_eff_r;
  ev_kind_t         s2_kind_r;
  stage_idx_t       s2_stage_r;
  stage_mask_t      shed_now;

  // monitoring off: report the current state with no event
  assign shed_now = monitor_r ? shed_nxt : shed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_pub_r <= 1'b0;
    end else if (s1_fire) begin
      s2_pub_r <= monitor_r && publish;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_sum_r   <= sum_add;
      s2_shed_r  <= shed_now;
      s2_eff_r   <= active_r & ~shed_now;
      s2_kind_r  <= monitor_r ? kind : EV_NONE;
      s2_stage_r <= monitor_r ? stage : '0;
    end
  end

  // ---------------------------------------------------------- average stage
  logic [PROD_W-1:0] avg_prod;
  rtf_t              avg_q;
  rtf_t              last_avg_r;
  stage_mask_t       out_shed_r;
  stage_mask_t       out_eff_r;
  ev_kind_t          out_kind_r;
  stage_idx_t        out_stage_r;

  assign avg_prod = PROD_W'(s2_sum_r) * PROD_W'(DIV_M);
  assign avg_q    = avg_prod[DIV_S +: RTF_W];

  // last_avg_r is the last published average; hold it when nothing publishes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_avg_r <= '0;
    end else if (s2_fire && s2_pub_r) begin
      last_avg_r <= avg_q;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_shed_r  <= s2_shed_r;
      out_eff_r   <= s2_eff_r;
      out_kind_r  <= s2_kind_r;
      out_stage_r <= s2_stage_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_shed_mask        = out_shed_r;
  assign out_effective_stages = out_eff_r;
  assign out_rolling_load     = last_avg_r;
  assign out_event_kind       = out_kind_r;
  assign out_event_stage      = out_stage_r;

endmodule

>>> hdl/lssp_stage_sel.sv
// Stage selection for the load-shedding policy: priority encoders that pick
// the next stage to shed and the next stage to restore. Uses lssp_pkg.
module lssp_stage_sel (
  input  lssp_pkg::stage_mask_t active,
  input  lssp_pkg::stage_mask_t shed,
  output lssp_pkg::sel_t        sel
);
  import lssp_pkg::*;

  stage_mask_t cand;

  assign cand = active & ~shed;

  always_comb begin
    sel.shed_ok  = |cand;
    sel.shed_idx = '0;
    sel.rest_idx = '0;
    // lowest candidate wins
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        sel.shed_idx = IDX_W'(i);
      end
    end
    // highest shed stage wins
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (shed[i]) begin
        sel.rest_idx = IDX_W'(i);
      end
    end
  end

endmodule

>>> hdl/lssp_check.sv
// Port-level checker for the load-shedding stage policy, plus its bind.
// Depends on lssp_pkg; attaches to load_shedding_stage_policy.
module lssp_check (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input lssp_pkg::stage_mask_t out_shed_mask,
  input lssp_pkg::stage_mask_t out_effective_stages,
  input lssp_pkg::rtf_t        out_rolling_load,
  input lssp_pkg::ev_kind_t    out_event_kind,
  input lssp_pkg::stage_idx_t  out_event_stage
);
  import lssp_pkg::*;

  stage_mask_t ev_bit;

  assign ev_bit = stage_mask_t'(1) << out_event_stage;

  // a quiet beat names no stage
  a_quiet_stage : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == EV_NONE) |-> out_event_stage == '0)
    else $error("event_stage set without an event");

  // a shed stage is never reported as effective
  a_eff_disjoint : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_effective_stages & out_shed_mask) == '0)
    else $error("shed stage still effective");

  // the reported stage agrees with the mask after the event
  a_event_mask : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_kind == EV_SHED || out_event_kind == EV_RESTORE))
      |-> (out_event_stage < IDX_W'(NUM_STAGES)) &&
          (((out_shed_mask & ev_bit) != '0) == (out_event_kind == EV_SHED)))
    else $error("event stage disagrees with shed mask");

  // a stalled result beat holds
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_shed_mask) &&
      $stable(out_effective_stages) && $stable(out_rolling_load) &&
      $stable(out_event_kind) && $stable(out_event_stage))
    else $error("stalled result beat changed");

endmodule

bind load_shedding_stage_policy lssp_check u_lssp_check (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_shed_mask        (out_shed_mask),
  .out_effective_stages (out_effective_stages),
  .out_rolling_load     (out_rolling_load),
  .out_event_kind       (out_event_kind),
  .out_event_stage      (out_event_stage)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for load_shedding_stage_policy: directed and random load beats,
// a per-beat policy predictor and an in-order result checker.
// Depends on lssp_pkg and the load_shedding_stage_policy RTL.
module tb_top;
  import lssp_pkg::*;

  localparam int WIN           = 16;
  // Three pipeline stages, plus margin before touching the registers.
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 500000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {LOAD_HIGH, LOAD_LOW, LOAD_MID, LOAD_EDGE, LOAD_NOISE} load_kind_t;

  // One result beat as the block should present it.
  typedef struct packed {
    stage_mask_t shed;
    stage_mask_t eff;
    rtf_t        avg;
    ev_kind_t    kind;
    stage_idx_t  stage;
  } policy_beat_t;

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  rtf_t                  in_block_rtf = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  stage_mask_t           out_shed_mask;
  stage_mask_t           out_effective_stages;
  rtf_t                  out_rolling_load;
  ev_kind_t              out_event_kind;
  stage_idx_t            out_event_stage;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  load_shedding_stage_policy #(.WINDOW(WIN)) DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_block_rtf         (in_block_rtf),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_shed_mask        (out_shed_mask),
    .out_effective_stages (out_effective_stages),
    .out_rolling_load     (out_rolling_load),
    .out_event_kind       (out_event_kind),
    .out_event_stage      (out_event_stage),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // Shadow of the policy: window ring, running sum, shed state, registers.
  rtf_t        win_ring [WIN];
  int          win_pos     = 0;
  int          win_fill    = 0;
  int          win_sum     = 0;
  stage_mask_t shed_state  = '0;
  rcnt_t       low_streak  = '0;
  rtf_t        avg_state   = '0;
  stage_mask_t reg_active  = ACTIVE_RST;
  logic        reg_monitor = 1'b1;
  rcnt_t       reg_recover = RECOVERY_RST;

  policy_beat_t expected_beats [$];
  int           errors       = 0;
  int           cycles       = 0;
  bit           tx_idle_on   = 1'b1;
  bit           rx_idle_on   = 1'b1;
  int           hold_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the shadow by one accepted load beat and return the result beat.
  function automatic policy_beat_t predict_policy(input rtf_t x);
    policy_beat_t r;
    stage_mask_t  cand;
    int           pick;
    bit           over;
    bit           under;
    r.kind  = EV_NONE;
    r.stage = '0;
    if (reg_monitor) begin
      // Once the window is full, the oldest entry leaves as the new one enters.
      if (win_fill >= WIN) win_sum = win_sum - int'(win_ring[win_pos]) + int'(x);
      else win_sum = win_sum + int'(x);
      win_ring[win_pos] = x;
      win_pos = (win_pos + 1) % WIN;
      if (win_fill < WIN) win_fill++;
      if (win_fill >= WIN) begin
        // Compare on the exact sum; the published average is truncated.
        over  = HI_DEN * win_sum > HI_NUM * RTF_ONE * WIN;
        under = LO_DEN * win_sum < LO_NUM * RTF_ONE * WIN;
        avg_state = rtf_t'(win_sum / WIN);
        if (over) begin
          cand = reg_active & ~shed_state;
          low_streak = '0;
          if (cand != '0) begin
            pick = 0;
            for (int i = NUM_STAGES - 1; i >= 0; i--) if (cand[i]) pick = i;
            shed_state[pick] = 1'b1;
            r.kind  = EV_SHED;
            r.stage = stage_idx_t'(pick);
            // Restart the window after a shed.
            win_fill = 0;
            win_pos  = 0;
            win_sum  = 0;
          end
        end else if (under && shed_state != '0) begin
          low_streak = low_streak + 1'b1;
          if (low_streak >= reg_recover) begin
            pick = 0;
            for (int i = 0; i < NUM_STAGES; i++) if (shed_state[i]) pick = i;
            low_streak = '0;
            shed_state[pick] = 1'b0;
            r.kind  = EV_RESTORE;
            r.stage = stage_idx_t'(pick);
          end
        end else begin
          low_streak = '0;
        end
      end
    end
    r.shed = shed_state;
    r.eff  = reg_active & ~shed_state;
    r.avg  = avg_state;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin : result_check
    policy_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual shed_mask %h",
                 $time, out_shed_mask);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        check_field("shed_mask", want.shed, out_shed_mask);
        check_field("effective_stages", want.eff, out_effective_stages);
        check_field("rolling_load", want.avg, out_rolling_load);
        check_field("event_kind", want.kind, out_event_kind);
        check_field("event_stage", want.stage, out_event_stage);
      end
    end
  end

  // Receiver: honor a long hold-off when one is requested, else stall in
  // random bursts while idling is on.
  initial begin : result_stall
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d result beats outstanding", $time, expected_beats.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one load beat, hold it until accepted, then maybe drop valid
  // for a random gap.
  task automatic send_beat(input rtf_t x);
    in_valid     <= 1'b1;
    in_block_rtf <= x;
    do @(posedge clk); while (in_stall);
    expected_beats = {expected_beats, predict_policy(x)};
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected beat is back and the pipe is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ACTIVE:   reg_active  = val;
      CFG_MONITOR:  reg_monitor = val[0];
      CFG_RECOVERY: reg_recover = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic rtf_t rand_load(input load_kind_t k);
    case (k)
      LOAD_HIGH:
        return ($urandom_range(0, 7) == 0) ? rtf_t'($urandom_range(9000, 65535))
                                           : rtf_t'($urandom_range(3400, 9000));
      LOAD_LOW: return rtf_t'($urandom_range(0, 2000));
      LOAD_MID: return rtf_t'($urandom_range(2100, 3200));
      // Straddle the 0.50 and 0.80 thresholds.
      LOAD_EDGE:
        return ($urandom_range(0, 1) == 0) ? rtf_t'($urandom_range(2044, 2052))
                                           : rtf_t'($urandom_range(3272, 3282));
      default: return rtf_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic load_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return LOAD_HIGH;
    if (r < 65) return LOAD_LOW;
    if (r < 75) return LOAD_MID;
    if (r < 85) return LOAD_EDGE;
    return LOAD_NOISE;
  endfunction

  task automatic run_burst(input load_kind_t k, input int n);
    repeat (n) send_beat(rand_load(k));
  endtask

  // Bursts of random load classes, long enough to fill and cross windows.
  task automatic run_mixed(input int total);
    int n;
    while (total > 0) begin
      n = $urandom_range(4, 40);
      if (n > total) n = total;
      run_burst(pick_kind(), n);
      total -= n;
    end
  endtask

  // Field extremes, a first shed, monitoring off, and an unknown register.
  task automatic test_directed();
    send_beat(16'h0000);
    send_beat(16'hFFFF);
    send_beat(16'h5555);
    send_beat(16'hAAAA);
    repeat (12) send_beat(16'hFFFF);
    // Ignored beats: state holds, bit 0 alone enables.
    write_reg(CFG_MONITOR, 10'h3FE);
    send_beat(16'hFFFF);
    send_beat(16'h0000);
    write_reg(CFG_MONITOR, 10'h001);
    write_reg(CFG_UNUSED, 10'h155);
    send_beat(16'h0001);
    send_beat(16'h8000);
  endtask

  // Shed every requested stage, then keep the load high with nothing left.
  task automatic test_shed_until_empty();
    stage_mask_t mask;
    mask = '0;
    repeat (3) mask[$urandom_range(0, NUM_STAGES - 1)] = 1'b1;
    write_reg(CFG_RECOVERY, 10'd1023);
    write_reg(CFG_ACTIVE, mask);
    run_burst(LOAD_HIGH, 4 * WIN);
    repeat (8) send_beat(16'hFFFF);
    // Window stays full, so the next high beat sheds right away.
    write_reg(CFG_ACTIVE, ACTIVE_RST);
    run_burst(LOAD_HIGH, 3 * WIN);
  endtask

  // Restore stages with short recovery counts, zero among them.
  task automatic test_restore();
    write_reg(CFG_RECOVERY, 10'd1);
    run_burst(LOAD_LOW, 24);
    write_reg(CFG_RECOVERY, 10'd0);
    run_burst(LOAD_LOW, 8);
    run_burst(LOAD_HIGH, 3 * WIN);
    write_reg(CFG_RECOVERY, 10'd3);
    run_burst(LOAD_LOW, 30);
  endtask

  // Shed stages that then leave the request mask; restore still works.
  task automatic test_stale_request();
    write_reg(CFG_ACTIVE, ACTIVE_RST);
    run_burst(LOAD_HIGH, 2 * WIN);
    write_reg(CFG_ACTIVE, 10'd0);
    run_burst(LOAD_HIGH, 20);
    write_reg(CFG_RECOVERY, 10'd2);
    run_burst(LOAD_LOW, 30);
  endtask

  // Build a long low streak, then lower recovery_blocks below it.
  task automatic test_recovery_lowered();
    write_reg(CFG_ACTIVE, ACTIVE_RST);
    write_reg(CFG_RECOVERY, 10'd1023);
    run_burst(LOAD_HIGH, 2 * WIN);
    run_burst(LOAD_LOW, 40);
    write_reg(CFG_RECOVERY, 10'd4);
    run_burst(LOAD_LOW, 6);
  endtask

  // Hold the receiver off while the sender keeps offering beats.
  task automatic test_backpressure();
    settle();
    tx_idle_on  = 1'b0;
    hold_cycles = 250;
    run_burst(LOAD_NOISE, 30);
    run_burst(LOAD_HIGH, 30);
    tx_idle_on  = 1'b1;
  endtask

  // Pause the sender until every result is back, then continue.
  task automatic test_sender_pause();
    run_burst(LOAD_LOW, 20);
    settle();
    run_burst(LOAD_HIGH, 20);
  endtask

  // Random phases, each with its own register settings.
  task automatic test_random_policy(input int phases);
    int r;
    repeat (phases) begin
      r = $urandom_range(0, 9);
      write_reg(CFG_ACTIVE, (r == 0) ? 10'd0 : (r == 1) ? ACTIVE_RST
                                     : CFG_DATA_W'($urandom_range(0, 1023)));
      r = $urandom_range(0, 9);
      write_reg(CFG_RECOVERY, (r == 0) ? 10'd0 : (r == 1) ? 10'd1023 : (r == 2) ? 10'd1
                                       : CFG_DATA_W'($urandom_range(1, 12)));
      write_reg(CFG_MONITOR, {9'($urandom_range(0, 511)), ($urandom_range(0, 9) != 0)});
      run_mixed(45);
    end
  endtask

  // Last stretch at full rate: no idling on either side.
  task automatic test_full_rate();
    write_reg(CFG_MONITOR, 10'd1);
    write_reg(CFG_RECOVERY, 10'd2);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_mixed(120);
  endtask

  initial begin
    for (int i = 0; i < WIN; i++) win_ring[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_shed_until_empty();
    test_restore();
    test_stale_request();
    test_recovery_lowered();
    test_backpressure();
    test_sender_pause();
    test_random_policy(3);
    test_full_rate();

    settle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
